// ===== rtl/core/tmvp_pkg.sv =====
// Shared types and constants for the transposed matrix-vector product core.
// Used by tmvp_front, tmvp_back and the top level; depends on nothing.
package tmvp_pkg;

  localparam int IDX_W       = 10;
  localparam int VAL_W       = 16;
  localparam int PROD_W      = 32;
  localparam int ACC_W       = 48;
  localparam int SIZE_W      = 11;
  localparam logic [SIZE_W-1:0] SIZE_RESET = 11'd1024;

  localparam int QUEUE_DEPTH = 4;
  localparam int QPTR_W      = $clog2(QUEUE_DEPTH);
  localparam int QCNT_W      = $clog2(QUEUE_DEPTH + 1);

  typedef struct packed {
    logic        [IDX_W-1:0] col;
    logic signed [VAL_W-1:0] matrix_value;
    logic signed [VAL_W-1:0] vector_value;
    logic                    first;
    logic                    last;
  } item_t;

endpackage

// ===== rtl/core/tmvp_front.sv =====
// Front end: size register, range check, first/last row tagging and the item queue.
// Depends on tmvp_pkg.
module tmvp_front #(
  parameter int MAX_SIZE = 1024
) (
  input  logic                                 clk,
  input  logic                                 rst,
  input  logic                                 cfg_valid,
  output logic                                 cfg_ready,
  input  logic        [tmvp_pkg::SIZE_W-1:0]   cfg_data,
  input  logic                                 in_valid,
  output logic                                 in_ready,
  input  logic        [tmvp_pkg::IDX_W-1:0]    row_index,
  input  logic        [tmvp_pkg::IDX_W-1:0]    col_index,
  input  logic signed [tmvp_pkg::VAL_W-1:0]    matrix_value,
  input  logic signed [tmvp_pkg::VAL_W-1:0]    vector_value,
  output logic                                 q_valid,
  output tmvp_pkg::item_t                      q_item,
  input  logic                                 q_pop
);
  import tmvp_pkg::*;

  localparam int MAX_W = $clog2(MAX_SIZE + 1);
  localparam int CMP_W = (MAX_W > SIZE_W) ? MAX_W : SIZE_W;

  logic [SIZE_W-1:0] size_in_use;
  logic [CMP_W-1:0]  size_ext;
  logic [CMP_W-1:0]  n_eff;
  logic [CMP_W-1:0]  row_ext;
  logic [CMP_W-1:0]  col_ext;
  logic              in_range;
  logic              push;
  item_t             new_item;

  item_t             queue_mem [QUEUE_DEPTH];
  logic [QPTR_W-1:0] wr_ptr;
  logic [QPTR_W-1:0] rd_ptr;
  logic [QCNT_W-1:0] count;
  logic [QCNT_W-1:0] count_next;

  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (rst) begin
      size_in_use <= SIZE_RESET;
    end else if (cfg_valid && cfg_ready) begin
      size_in_use <= cfg_data;
    end
  end

  // clamp size to 1..MAX_SIZE
  always_comb begin
    size_ext = CMP_W'(size_in_use);
    if (size_ext == '0) begin
      n_eff = CMP_W'(1);
    end else if (size_ext > CMP_W'(MAX_SIZE)) begin
      n_eff = CMP_W'(MAX_SIZE);
    end else begin
      n_eff = size_ext;
    end
  end

  assign row_ext  = CMP_W'(row_index);
  assign col_ext  = CMP_W'(col_index);
  assign in_range = (row_ext < n_eff) && (col_ext < n_eff);
  assign in_ready = (count != QCNT_W'(QUEUE_DEPTH));
  // drop out-of-range items here
  assign push     = in_valid && in_ready && in_range;

  always_comb begin
    new_item.col          = col_index;
    new_item.matrix_value = matrix_value;
    new_item.vector_value = vector_value;
    new_item.first        = (row_index == '0);
    new_item.last         = (row_ext == n_eff - CMP_W'(1));
  end

  always_ff @(posedge clk) begin
    if (push) begin
      queue_mem[wr_ptr] <= new_item;
    end
  end

  always_comb begin
    case ({push, q_pop})
      2'b10:   count_next = count + QCNT_W'(1);
      2'b01:   count_next = count - QCNT_W'(1);
      default: count_next = count;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      count <= count_next;
      if (push) begin
        wr_ptr <= (wr_ptr == QPTR_W'(QUEUE_DEPTH - 1)) ? '0 : wr_ptr + QPTR_W'(1);
      end
      if (q_pop) begin
        rd_ptr <= (rd_ptr == QPTR_W'(QUEUE_DEPTH - 1)) ? '0 : rd_ptr + QPTR_W'(1);
      end
    end
  end

  assign q_valid = (count != '0);
  assign q_item  = queue_mem[rd_ptr];

  a_no_pop_empty: assert property (@(posedge clk) disable iff (rst)
    q_pop |-> q_valid)
    else $error("queue popped while empty");

  a_count_bound: assert property (@(posedge clk) disable iff (rst)
    count <= QCNT_W'(QUEUE_DEPTH))
    else $error("queue count above depth");

endmodule

// ===== rtl/core/tmvp_back.sv =====
// Back end: multiply, accumulator memory read-modify-write with bypass, output register.
// Depends on tmvp_pkg.
module tmvp_back #(
  parameter int MAX_SIZE = 1024
) (
  input  logic                                 clk,
  input  logic                                 rst,
  input  logic                                 q_valid,
  input  tmvp_pkg::item_t                      q_item,
  output logic                                 q_pop,
  output logic                                 out_valid,
  input  logic                                 out_ready,
  output logic        [tmvp_pkg::IDX_W-1:0]    result_column,
  output logic signed [tmvp_pkg::ACC_W-1:0]    column_sum
);
  import tmvp_pkg::*;

  localparam int AW     = (MAX_SIZE > 1) ? $clog2(MAX_SIZE) : 1;
  localparam int AEXT_W = (AW > IDX_W) ? AW : IDX_W;

  logic                     adv;
  logic                     s1_v;
  item_t                    s1;
  logic signed [PROD_W-1:0] s1_m_ext;
  logic signed [PROD_W-1:0] s1_v_ext;
  logic [AEXT_W-1:0]        s1_col_ext;
  logic [AW-1:0]            s1_addr;

  logic                     s2_v;
  logic [IDX_W-1:0]         s2_col;
  logic                     s2_first;
  logic                     s2_last;
  logic signed [PROD_W-1:0] s2_prod;
  logic [AEXT_W-1:0]        s2_col_ext;
  logic [AW-1:0]            s2_addr;

  logic [ACC_W-1:0]         acc_mem [MAX_SIZE];
  logic [ACC_W-1:0]         rd_data;
  logic                     wr_v;
  logic [IDX_W-1:0]         wr_col;
  logic [ACC_W-1:0]         wr_data;
  logic                     fwd_hit;
  logic [ACC_W-1:0]         acc_base;
  logic [ACC_W-1:0]         acc_sum;

  // advance whole pipe when output register is free or being drained
  assign adv   = !out_valid || out_ready;
  assign q_pop = adv && q_valid;

  assign s1_m_ext   = PROD_W'($signed(s1.matrix_value));
  assign s1_v_ext   = PROD_W'($signed(s1.vector_value));
  assign s1_col_ext = AEXT_W'(s1.col);
  assign s1_addr    = s1_col_ext[AW-1:0];
  assign s2_col_ext = AEXT_W'(s2_col);
  assign s2_addr    = s2_col_ext[AW-1:0];

  always_ff @(posedge clk) begin
    if (rst) begin
      s1_v <= 1'b0;
      s2_v <= 1'b0;
      wr_v <= 1'b0;
    end else if (adv) begin
      s1_v <= q_valid;
      s2_v <= s1_v;
      wr_v <= s2_v;
    end
  end

  always_ff @(posedge clk) begin
    if (q_pop) begin
      s1 <= q_item;
    end
    if (adv) begin
      s2_col   <= s1.col;
      s2_first <= s1.first;
      s2_last  <= s1.last;
      s2_prod  <= s1_m_ext * s1_v_ext;
      wr_col   <= s2_col;
      wr_data  <= acc_sum;
    end
  end

  always_ff @(posedge clk) begin
    if (adv && s1_v) begin
      rd_data <= acc_mem[s1_addr];
    end
  end

  always_ff @(posedge clk) begin
    if (adv && s2_v) begin
      acc_mem[s2_addr] <= acc_sum;
    end
  end

  // bypass the write made at the edge this item was read
  assign fwd_hit  = wr_v && (wr_col == s2_col);
  assign acc_base = s2_first ? '0 : (fwd_hit ? wr_data : rd_data);
  assign acc_sum  = acc_base + ACC_W'(s2_prod);

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (adv) begin
      out_valid <= s2_v && s2_last;
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      result_column <= s2_col;
      column_sum    <= acc_sum;
    end
  end

  a_stall_no_pop: assert property (@(posedge clk) disable iff (rst)
    (out_valid && !out_ready) |-> !q_pop)
    else $error("queue popped while output stalled");

  a_pop_fills_s1: assert property (@(posedge clk) disable iff (rst)
    q_pop |=> s1_v)
    else $error("popped item lost before first stage");

  a_last_emits: assert property (@(posedge clk) disable iff (rst)
    (adv && s2_v && s2_last) |=> out_valid)
    else $error("last row produced no result");

  a_bypass_track: assert property (@(posedge clk) disable iff (rst)
    (adv && s2_v) |=> (wr_v && wr_col == $past(s2_col)))
    else $error("bypass register out of step with write");

endmodule

// ===== rtl/core/transposed_matrix_vector_product_core.sv =====
// Top level of the transposed matrix-vector product core: front end plus back end.
// Depends on tmvp_pkg, tmvp_front and tmvp_back.
//
//  channel  handshake              payload
//  cfg      cfg_valid/cfg_ready    cfg_data (size_in_use, 11 b)
//  in       in_valid/in_ready      row_index, col_index, matrix_value, vector_value
//  out      out_valid/out_ready    result_column, column_sum
//
// One item per cycle sustained unless the output stalls; the accumulator memory takes
// a read and a write each cycle, which sets that rate. out_valid is registered after s2.
// Reset clears control only; accumulator memory is not cleared (row 0 loads it).
// A stalled output holds the back end; the 4-entry queue takes at most four more transfers.
module transposed_matrix_vector_product_core #(
  parameter int MAX_SIZE = 1024
) (
  input  logic                                 clk,
  input  logic                                 rst,
  input  logic                                 cfg_valid,
  output logic                                 cfg_ready,
  input  logic        [tmvp_pkg::SIZE_W-1:0]   cfg_data,
  input  logic                                 in_valid,
  output logic                                 in_ready,
  input  logic        [tmvp_pkg::IDX_W-1:0]    row_index,
  input  logic        [tmvp_pkg::IDX_W-1:0]    col_index,
  input  logic signed [tmvp_pkg::VAL_W-1:0]    matrix_value,
  input  logic signed [tmvp_pkg::VAL_W-1:0]    vector_value,
  output logic                                 out_valid,
  input  logic                                 out_ready,
  output logic        [tmvp_pkg::IDX_W-1:0]    result_column,
  output logic signed [tmvp_pkg::ACC_W-1:0]    column_sum
);
  import tmvp_pkg::*;

  logic  q_valid;
  item_t q_item;
  logic  q_pop;

  tmvp_front #(
    .MAX_SIZE (MAX_SIZE)
  ) u_front (
    .clk          (clk),
    .rst          (rst),
    .cfg_valid    (cfg_valid),
    .cfg_ready    (cfg_ready),
    .cfg_data     (cfg_data),
    .in_valid     (in_valid),
    .in_ready     (in_ready),
    .row_index    (row_index),
    .col_index    (col_index),
    .matrix_value (matrix_value),
    .vector_value (vector_value),
    .q_valid      (q_valid),
    .q_item       (q_item),
    .q_pop        (q_pop)
  );

  tmvp_back #(
    .MAX_SIZE (MAX_SIZE)
  ) u_back (
    .clk           (clk),
    .rst           (rst),
    .q_valid       (q_valid),
    .q_item        (q_item),
    .q_pop         (q_pop),
    .out_valid     (out_valid),
    .out_ready     (out_ready),
    .result_column (result_column),
    .column_sum    (column_sum)
  );

endmodule

// ===== bench/tb_transposed_matrix_vector_product_core.sv =====
// Self-checking bench for transposed_matrix_vector_product_core: streams matrix elements,
// predicts every finished column sum and compares it with each result transfer.
// Depends on tmvp_pkg and the core RTL only.
module tb_transposed_matrix_vector_product_core;
  timeunit 1ns;
  timeprecision 1ps;
  import tmvp_pkg::*;

  localparam int MAX_SIZE     = 1024;
  localparam int LATENCY      = 4;
  localparam int SETTLE       = 3 * LATENCY;
  localparam int HOLD_CYCLES  = 200;
  localparam int CYCLE_LIMIT  = 1_000_000;
  localparam int PHASE_ITEMS  = 104;
  localparam logic signed [VAL_W-1:0] VAL_MIN = 16'sh8000;
  localparam logic signed [VAL_W-1:0] VAL_MAX = 16'sh7fff;

  typedef struct {
    logic        [IDX_W-1:0] col;
    logic signed [ACC_W-1:0] sum;
  } column_sum_t;

  logic                     clk = 1'b0;
  logic                     rst = 1'b1;
  logic                     cfg_valid = 1'b0;
  logic                     cfg_ready;
  logic        [SIZE_W-1:0] cfg_data = '0;
  logic                     in_valid = 1'b0;
  logic                     in_ready;
  logic        [IDX_W-1:0]  row_index = '0;
  logic        [IDX_W-1:0]  col_index = '0;
  logic signed [VAL_W-1:0]  matrix_value = '0;
  logic signed [VAL_W-1:0]  vector_value = '0;
  logic                     out_valid;
  logic                     out_ready = 1'b0;
  logic        [IDX_W-1:0]  result_column;
  logic signed [ACC_W-1:0]  column_sum;

  column_sum_t              pending_sums[$];
  logic signed [ACC_W-1:0]  col_acc [MAX_SIZE];
  bit                       acc_written [MAX_SIZE];
  logic        [SIZE_W-1:0] size_setting = SIZE_RESET;

  bit feeding       = 1'b0;
  bit steady        = 1'b0;
  bit hold_request  = 1'b0;
  int cycles        = 0;
  int elements_sent = 0;
  int elements_used = 0;
  int sums_checked  = 0;
  int sizes_written = 0;
  int mismatches    = 0;

  transposed_matrix_vector_product_core #(.MAX_SIZE(MAX_SIZE)) DUT (
    .clk          (clk),
    .rst          (rst),
    .cfg_valid    (cfg_valid),
    .cfg_ready    (cfg_ready),
    .cfg_data     (cfg_data),
    .in_valid     (in_valid),
    .in_ready     (in_ready),
    .row_index    (row_index),
    .col_index    (col_index),
    .matrix_value (matrix_value),
    .vector_value (vector_value),
    .out_valid    (out_valid),
    .out_ready    (out_ready),
    .result_column(result_column),
    .column_sum   (column_sum)
  );

  initial begin
    forever #10 clk = ~clk;
  end

  initial begin
    while (cycles < CYCLE_LIMIT) begin
      @(posedge clk);
      cycles++;
    end
    $display("Simulation FAILED");
    $finish;
  end

  function automatic int active_size();
    if (size_setting == 0) return 1;
    if (size_setting > MAX_SIZE) return MAX_SIZE;
    return int'(size_setting);
  endfunction

  function automatic int idle_span();
    int r;
    r = $urandom_range(0, 99);
    if (steady || r < 55) return 0;
    if (r < 90) return $urandom_range(1, 3);
    return $urandom_range(8, 30);
  endfunction

  function automatic logic signed [VAL_W-1:0] pick_value();
    int r;
    r = $urandom_range(0, 9);
    if (r == 0) return VAL_MIN;
    if (r == 1) return VAL_MAX;
    return VAL_W'($urandom());
  endfunction

  function automatic void accumulate_element(input logic [IDX_W-1:0] row,
                                             input logic [IDX_W-1:0] col,
                                             input logic signed [VAL_W-1:0] mval,
                                             input logic signed [VAL_W-1:0] vval);
    int n;
    logic signed [PROD_W-1:0] prod;
    logic signed [ACC_W-1:0]  acc;
    column_sum_t              done;
    n = active_size();
    if (row >= n || col >= n) return;
    elements_used++;
    prod = PROD_W'(mval) * PROD_W'(vval);
    acc = {{(ACC_W-PROD_W){prod[PROD_W-1]}}, prod};
    if (row != 0) acc = col_acc[col] + acc;
    col_acc[col] = acc;
    acc_written[col] = 1'b1;
    if (row == n - 1) begin
      done.col = col;
      done.sum = acc;
      pending_sums.push_back(done);
    end
  endfunction

  task automatic send_element(input logic [IDX_W-1:0] row, input logic [IDX_W-1:0] col,
                              input logic signed [VAL_W-1:0] mval,
                              input logic signed [VAL_W-1:0] vval);
    int gap;
    gap = idle_span();
    if (gap > 0 && feeding) begin
      in_valid <= 1'b0;
      feeding = 1'b0;
    end
    repeat (gap) @(posedge clk);
    in_valid     <= 1'b1;
    feeding      = 1'b1;
    row_index    <= row;
    col_index    <= col;
    matrix_value <= mval;
    vector_value <= vval;
    do @(posedge clk); while (!in_ready);
    elements_sent++;
    accumulate_element(row, col, mval, vval);
  endtask

  task automatic wait_idle();
    if (feeding) begin
      in_valid <= 1'b0;
      feeding = 1'b0;
      @(posedge clk);
    end
    while (pending_sums.size() != 0) @(posedge clk);
    repeat (SETTLE) @(posedge clk);
  endtask

  task automatic write_size(input logic [SIZE_W-1:0] value);
    wait_idle();
    cfg_valid <= 1'b1;
    cfg_data  <= value;
    do @(posedge clk); while (!cfg_ready);
    cfg_valid <= 1'b0;
    size_setting = value;
    sizes_written++;
    @(posedge clk);
  endtask

  task automatic test_reset_size();
    send_element(0, 1023, VAL_MIN, VAL_MIN);
    send_element(512, 1023, VAL_MAX, VAL_MIN);
    send_element(1023, 1023, VAL_MAX, VAL_MAX);
    send_element(0, 0, 0, -1);
    send_element(1023, 0, -1, 1);
  endtask

  task automatic test_size_zero();
    write_size(0);
    send_element(0, 0, VAL_MIN, VAL_MAX);
    send_element(1, 0, pick_value(), pick_value());
    send_element(0, 1, pick_value(), pick_value());
    send_element(0, 0, 1, -1);
  endtask

  task automatic test_oversize();
    write_size(2047);
    send_element(0, 5, pick_value(), pick_value());
    send_element(1023, 5, pick_value(), pick_value());
  endtask

  task automatic test_out_of_range();
    write_size(4);
    send_element(4, 0, pick_value(), pick_value());
    send_element(0, 4, pick_value(), pick_value());
    send_element(1023, 1023, pick_value(), pick_value());
    send_element(0, 3, VAL_MAX, VAL_MIN);
    send_element(3, 3, VAL_MIN, VAL_MIN);
  endtask

  task automatic test_row_order();
    int rows [7] = '{0, 3, 1, 3, 0, 2, 3};
    write_size(4);
    foreach (rows[i]) send_element(IDX_W'(rows[i]), 2, pick_value(), pick_value());
  endtask

  task automatic run_random_phase(input logic [SIZE_W-1:0] setting, input int target);
    int n, used, k, span;
    int stream_row [4];
    int stream_col [4];
    bit stream_live [4];
    logic [IDX_W-1:0] row, col;
    write_size(setting);
    n = active_size();
    used = 0;
    stream_live = '{default: 1'b0};
    steady = ($urandom_range(0, 3) == 0);
    while (used < target) begin
      k = $urandom_range(0, 3);
      if ($urandom_range(0, 99) < 85) begin
        if (!stream_live[k]) begin
          stream_col[k]  = $urandom_range(0, n - 1);
          stream_row[k]  = 0;
          stream_live[k] = 1'b1;
        end else begin
          span = n - 1 - stream_row[k];
          stream_row[k] += (span <= 1) ? span : $urandom_range(1, (span + 2) / 3);
        end
        row = IDX_W'(stream_row[k]);
        col = IDX_W'(stream_col[k]);
        if (stream_row[k] == n - 1) stream_live[k] = 1'b0;
      end else begin
        row = IDX_W'($urandom_range(0, MAX_SIZE - 1));
        col = IDX_W'($urandom_range(0, MAX_SIZE - 1));
        if (row < n && col < n && row != 0 && !acc_written[col]) row = '0;
      end
      if (row < n && col < n) used++;
      send_element(row, col, pick_value(), pick_value());
    end
    steady = 1'b0;
  endtask

  task automatic test_random_phases();
    logic [SIZE_W-1:0] phase_sizes [14] =
      '{1, 2, 3, 4, 7, 16, 64, 1024, 0, 2047, 1025, 5, 300, 1};
    foreach (phase_sizes[i]) run_random_phase(phase_sizes[i], PHASE_ITEMS);
  endtask

  task automatic test_backpressure();
    write_size(1);
    steady = 1'b1;
    hold_request = 1'b1;
    repeat (30) send_element(0, 0, pick_value(), pick_value());
    steady = 1'b0;
  endtask

  task automatic test_drain_pause();
    write_size(8);
    for (int col = 0; col < 8; col++) begin
      if (col == 4) begin
        wait_idle();
      end
      for (int row = 0; row < 8; row++) begin
        send_element(IDX_W'(row), IDX_W'(col), pick_value(), pick_value());
      end
    end
  endtask

  initial begin : sum_receiver
    int stall_left;
    int gap;
    column_sum_t want;
    stall_left = 0;
    forever begin
      @(posedge clk);
      if (!rst && out_valid && out_ready) begin
        if (pending_sums.size() == 0) begin
          $error("unexpected transfer: column %0d sum %0d", result_column, column_sum);
          mismatches++;
        end else begin
          want = pending_sums.pop_front();
          sums_checked++;
          if (result_column !== want.col) begin
            $error("result_column: expected %0d, actual %0d", want.col, result_column);
            mismatches++;
          end
          if (column_sum !== want.sum) begin
            $error("column_sum: expected %0d, actual %0d", want.sum, column_sum);
            mismatches++;
          end
        end
      end
      if (hold_request) begin
        stall_left = HOLD_CYCLES;
        hold_request = 1'b0;
      end
      if (stall_left > 0) begin
        out_ready <= 1'b0;
        stall_left--;
      end else begin
        gap = idle_span();
        if (gap == 0) begin
          out_ready <= 1'b1;
        end else begin
          out_ready <= 1'b0;
          stall_left = gap - 1;
        end
      end
    end
  end

  initial begin
    repeat (8) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);
    test_reset_size();
    test_size_zero();
    test_oversize();
    test_out_of_range();
    test_row_order();
    test_random_phases();
    test_backpressure();
    test_drain_pause();
    wait_idle();
    $display("Sent %0d element transfers, %0d inside the active size, over %0d size settings.",
             elements_sent, elements_used, sizes_written);
    $display("Checked %0d column sums; %0d mismatches.", sums_checked, mismatches);
    if (mismatches == 0 && pending_sums.size() == 0) begin
      $display("Simulation PASSED");
    end else begin
      $display("Simulation FAILED");
    end
    $finish;
  end

endmodule
